>>> design/lrfb_pkg.sv
`default_nettype none

package lrfb_pkg;

    // command word
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] level;
        logic [5:0] first_index;
        logic [6:0] end_index;
    } t_cmd;

    // refresh result word
    typedef struct packed {
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic [7:0] out_blue;
        logic       last_pixel;
    } t_result;

    // command kinds
    localparam logic [2:0] KIND_SET     = 3'd0;
    localparam logic [2:0] KIND_BAR     = 3'd1;
    localparam logic [2:0] KIND_RING_A  = 3'd2;
    localparam logic [2:0] KIND_RING_B  = 3'd3;
    localparam logic [2:0] KIND_FILL    = 3'd4;
    localparam logic [2:0] KIND_BRIGHT  = 3'd5;
    localparam logic [2:0] KIND_REFRESH = 3'd6;

    // configuration register indexes
    localparam logic [2:0] CFG_RING_SIZE      = 3'd0;
    localparam logic [2:0] CFG_RING_A_START   = 3'd1;
    localparam logic [2:0] CFG_RING_A_OFFSET  = 3'd2;
    localparam logic [2:0] CFG_RING_A_REVERSE = 3'd3;
    localparam logic [2:0] CFG_RING_B_START   = 3'd4;
    localparam logic [2:0] CFG_RING_B_OFFSET  = 3'd5;
    localparam logic [2:0] CFG_RING_B_REVERSE = 3'd6;

    // configuration reset values
    localparam logic [6:0] RING_SIZE_RST      = 7'd24;
    localparam logic [5:0] RING_A_START_RST   = 6'd24;
    localparam logic [5:0] RING_A_OFFSET_RST  = 6'd11;
    localparam logic       RING_A_REVERSE_RST = 1'b1;
    localparam logic [5:0] RING_B_START_RST   = 6'd0;
    localparam logic [5:0] RING_B_OFFSET_RST  = 6'd23;
    localparam logic       RING_B_REVERSE_RST = 1'b0;

endpackage

`default_nettype wire

>>> design/led_ring_frame_buffer.sv
`default_nettype none

// LED ring frame buffer. Commands are taken on start while busy is low;
// every command is done one store entry per cycle from two synchronous
// memories (color and brightness): set pixel writes one entry, a linear
// bar walks end_index - first_index entries, a ring bar works out its
// position remainder and then walks end_index - first_index entries, fill
// and brightness fill walk all NUM_LEDS entries, a refresh reads them all.
// Refresh words come out on o_strobe, one per cycle, LED NUM_LEDS-1 first,
// through the read, product, quotient and output registers; the receiver
// cannot stall, and busy drops once the last entry is read, so the next
// command may be taken while the last words are still on their way. Empty
// bars, brightness fills that are out of range or hold the no-change code,
// and unused kinds are taken and finish at once.
// Reset clears per-entry valid flags, so no clearing pass is needed.
// Configuration is written through the cfg channel, which is always ready.
module led_ring_frame_buffer #(
    parameter int NUM_LEDS       = 48,
    parameter int BRIGHT_MAX     = 15,
    parameter int NO_CHANGE_CODE = 255
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire lrfb_pkg::t_cmd    i_cmd,
    output logic                   busy,
    output logic                   o_strobe,
    output lrfb_pkg::t_result      o_result,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [2:0]        i_cfg_index,
    input  wire logic [6:0]        i_cfg_data
);

    localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int RECIP_SHIFT = 24;
    localparam logic [24:0] RECIP =
        25'(((1 << RECIP_SHIFT) + BRIGHT_MAX - 1) / BRIGHT_MAX);
    localparam logic [7:0] NCC      = 8'(NO_CHANGE_CODE);
    localparam logic [7:0] BMAX     = 8'(BRIGHT_MAX);
    localparam logic [7:0] NUM8     = 8'(NUM_LEDS);
    localparam logic [6:0] FILL_END = 7'(NUM_LEDS);
    localparam logic [6:0] LAST_POS = 7'(NUM_LEDS - 1);
    localparam logic [2:0] MOD_LAST = 3'd6;

    typedef enum logic [1:0] {S_IDLE, S_MOD, S_WALK, S_SCAN} t_state;
    typedef enum logic [1:0] {OP_LINE, OP_RING, OP_BRIGHT} t_op;

    // configuration registers
    logic [6:0] r_ring_size;
    logic [5:0] r_a_start, r_a_offset, r_b_start, r_b_offset;
    logic       r_a_rev, r_b_rev;

    // sequencer
    t_state     r_state;
    t_op        r_op;
    logic [6:0] r_pos, r_end;
    logic [7:0] r_red, r_green, r_blue, r_level;
    logic [5:0] r_start;
    logic [6:0] r_n, r_t, r_div, r_rem;
    logic       r_rev, r_neg;
    logic [2:0] r_cnt;

    // memories and valid flags
    logic [23:0]         r_col_mem [NUM_LEDS];
    logic [7:0]          r_brt_mem [NUM_LEDS];
    logic [NUM_LEDS-1:0] r_col_ok, r_brt_ok;

    // refresh pipeline
    logic        r_s1_vld, r_s1_last, r_s2_vld, r_s2_last, r_s3_vld, r_s3_last;
    logic [23:0] r_rd_col;
    logic [7:0]  r_rd_brt;
    logic        r_rd_col_ok, r_rd_brt_ok;
    logic [15:0] r_p_g, r_p_r, r_p_b;
    logic [16:0] r_q_g, r_q_r, r_q_b;
    logic        r_out_vld;
    lrfb_pkg::t_result r_out;

    // combinational
    logic [7:0]  rem_sh, rem_nx;
    logic [6:0]  t_init, t_step;
    logic [7:0]  idx;
    logic        in_range, col_we, brt_we;
    logic [AW-1:0] waddr, raddr;
    logic [6:0]  acc_n;
    logic [5:0]  acc_off;
    logic        acc_rev, acc_neg;
    logic [6:0]  acc_div;
    logic [23:0] col_m;
    logic [7:0]  brt_m;
    logic [40:0] m_g, m_r, m_b;

    function automatic logic [7:0] sat8(input logic [16:0] q);
        return (q > 17'd255) ? 8'hFF : q[7:0];
    endfunction

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_out_vld;
    assign o_result    = r_out;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size <= lrfb_pkg::RING_SIZE_RST;
            r_a_start   <= lrfb_pkg::RING_A_START_RST;
            r_a_offset  <= lrfb_pkg::RING_A_OFFSET_RST;
            r_a_rev     <= lrfb_pkg::RING_A_REVERSE_RST;
            r_b_start   <= lrfb_pkg::RING_B_START_RST;
            r_b_offset  <= lrfb_pkg::RING_B_OFFSET_RST;
            r_b_rev     <= lrfb_pkg::RING_B_REVERSE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                lrfb_pkg::CFG_RING_SIZE:      r_ring_size <= i_cfg_data;
                lrfb_pkg::CFG_RING_A_START:   r_a_start   <= i_cfg_data[5:0];
                lrfb_pkg::CFG_RING_A_OFFSET:  r_a_offset  <= i_cfg_data[5:0];
                lrfb_pkg::CFG_RING_A_REVERSE: r_a_rev     <= i_cfg_data[0];
                lrfb_pkg::CFG_RING_B_START:   r_b_start   <= i_cfg_data[5:0];
                lrfb_pkg::CFG_RING_B_OFFSET:  r_b_offset  <= i_cfg_data[5:0];
                lrfb_pkg::CFG_RING_B_REVERSE: r_b_rev     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ring setup operands picked at command accept
    always_comb begin
        acc_n   = (r_ring_size == 7'd0) ? 7'd1 : r_ring_size;
        acc_off = (i_cmd.kind == lrfb_pkg::KIND_RING_A) ? r_a_offset : r_b_offset;
        acc_rev = (i_cmd.kind == lrfb_pkg::KIND_RING_A) ? r_a_rev : r_b_rev;
        acc_neg = 1'b0;
        if (!acc_rev) begin
            acc_div = {1'b0, acc_off} + {1'b0, i_cmd.first_index};
        end else if (acc_off >= i_cmd.first_index) begin
            acc_div = {1'b0, acc_off - i_cmd.first_index};
        end else begin
            acc_div = {1'b0, i_cmd.first_index - acc_off};
            acc_neg = 1'b1;
        end
    end

    // one restoring remainder step, then the true-modulo fixup
    always_comb begin
        rem_sh = {r_rem, r_div[6]};
        rem_nx = (rem_sh >= {1'b0, r_n}) ? rem_sh - {1'b0, r_n} : rem_sh;
        t_init = (r_neg && rem_nx[6:0] != 7'd0) ? r_n - rem_nx[6:0] : rem_nx[6:0];
    end

    // ring position step with wrap
    always_comb begin
        if (!r_rev) begin
            t_step = (r_t + 7'd1 == r_n) ? 7'd0 : r_t + 7'd1;
        end else begin
            t_step = (r_t == 7'd0) ? r_n - 7'd1 : r_t - 7'd1;
        end
    end

    // write target and enables
    always_comb begin
        idx      = (r_op == OP_RING) ? {2'b00, r_start} + {1'b0, r_t} : {1'b0, r_pos};
        in_range = (idx < NUM8);
        col_we   = (r_state == S_WALK) && in_range && (r_op != OP_BRIGHT);
        brt_we   = (r_state == S_WALK) && in_range && ((r_op == OP_BRIGHT) || (r_level != NCC));
        waddr    = idx[AW-1:0];
        raddr    = r_pos[AW-1:0];
    end

    // command sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_red   <= i_cmd.red;
                        r_green <= i_cmd.green;
                        r_blue  <= i_cmd.blue;
                        r_level <= i_cmd.level;
                        unique case (i_cmd.kind) inside
                            lrfb_pkg::KIND_SET: begin
                                r_op    <= OP_LINE;
                                r_pos   <= {1'b0, i_cmd.first_index};
                                r_end   <= {1'b0, i_cmd.first_index} + 7'd1;
                                r_state <= S_WALK;
                            end
                            lrfb_pkg::KIND_BAR: begin
                                r_op  <= OP_LINE;
                                r_pos <= {1'b0, i_cmd.first_index};
                                r_end <= i_cmd.end_index;
                                if (i_cmd.end_index > {1'b0, i_cmd.first_index}) begin
                                    r_state <= S_WALK;
                                end
                            end
                            lrfb_pkg::KIND_RING_A, lrfb_pkg::KIND_RING_B: begin
                                r_op    <= OP_RING;
                                r_pos   <= {1'b0, i_cmd.first_index};
                                r_end   <= i_cmd.end_index;
                                r_start <= (i_cmd.kind == lrfb_pkg::KIND_RING_A) ?
                                           r_a_start : r_b_start;
                                r_n     <= acc_n;
                                r_rev   <= acc_rev;
                                r_neg   <= acc_neg;
                                r_div   <= acc_div;
                                r_rem   <= 7'd0;
                                r_cnt   <= 3'd0;
                                if (i_cmd.end_index > {1'b0, i_cmd.first_index}) begin
                                    r_state <= S_MOD;
                                end
                            end
                            lrfb_pkg::KIND_FILL: begin
                                r_op    <= OP_LINE;
                                r_pos   <= 7'd0;
                                r_end   <= FILL_END;
                                r_state <= S_WALK;
                            end
                            lrfb_pkg::KIND_BRIGHT: begin
                                r_op  <= OP_BRIGHT;
                                r_pos <= 7'd0;
                                r_end <= FILL_END;
                                if (i_cmd.level != NCC && i_cmd.level <= BMAX) begin
                                    r_state <= S_WALK;
                                end
                            end
                            lrfb_pkg::KIND_REFRESH: begin
                                r_pos   <= LAST_POS;
                                r_state <= S_SCAN;
                            end
                            default: ;
                        endcase
                    end
                end
                S_MOD: begin
                    r_rem <= rem_nx[6:0];
                    r_div <= {r_div[5:0], 1'b0};
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == MOD_LAST) begin
                        r_t     <= t_init;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    r_pos <= r_pos + 7'd1;
                    r_t   <= t_step;
                    if ({1'b0, r_pos} + 8'd1 >= {1'b0, r_end}) begin
                        r_state <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (r_pos == 7'd0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_pos <= r_pos - 7'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // pixel memories
    always_ff @(posedge i_clk) begin
        if (col_we) begin
            r_col_mem[waddr] <= {r_blue, r_green, r_red};
        end
        if (brt_we) begin
            r_brt_mem[waddr] <= r_level;
        end
        r_rd_col    <= r_col_mem[raddr];
        r_rd_brt    <= r_brt_mem[raddr];
        r_rd_col_ok <= r_col_ok[raddr];
        r_rd_brt_ok <= r_brt_ok[raddr];
    end

    // entry valid flags, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_ok <= '0;
            r_brt_ok <= '0;
        end else begin
            if (col_we) begin
                r_col_ok[waddr] <= 1'b1;
            end
            if (brt_we) begin
                r_brt_ok[waddr] <= 1'b1;
            end
        end
    end

    // never-written entries read as zero
    always_comb begin
        col_m = r_rd_col_ok ? r_rd_col : 24'd0;
        brt_m = r_rd_brt_ok ? r_rd_brt : 8'd0;
        m_g   = 41'(r_p_g) * 41'(RECIP);
        m_r   = 41'(r_p_r) * 41'(RECIP);
        m_b   = 41'(r_p_b) * 41'(RECIP);
    end

    // refresh pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= (r_state == S_SCAN);
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_out_vld <= r_s3_vld;
        end
    end

    // scale by brightness, divide by BRIGHT_MAX through a reciprocal multiply, saturate
    always_ff @(posedge i_clk) begin
        r_s1_last <= (r_pos == 7'd0);
        r_s2_last <= r_s1_last;
        r_s3_last <= r_s2_last;
        r_p_r     <= col_m[7:0] * brt_m;
        r_p_g     <= col_m[15:8] * brt_m;
        r_p_b     <= col_m[23:16] * brt_m;
        r_q_g     <= m_g[40:RECIP_SHIFT];
        r_q_r     <= m_r[40:RECIP_SHIFT];
        r_q_b     <= m_b[40:RECIP_SHIFT];
        r_out.out_green  <= sat8(r_q_g);
        r_out.out_red    <= sat8(r_q_r);
        r_out.out_blue   <= sat8(r_q_b);
        r_out.last_pixel <= r_s3_last;
    end

    // checks
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_WALK) |-> !(col_we || brt_we))
        else $error("pixel store written outside a walk");

    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_pos == 7'd0) |-> ##4 (r_out_vld && r_out.last_pixel))
        else $error("final refresh word missing or not flagged");

    a_ring_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && r_op == OP_RING) |-> (r_t < r_n))
        else $error("ring position out of ring");

endmodule

`default_nettype wire

>>> tb/led_ring_frame_buffer_tb.sv
`timescale 1ns / 100ps

module led_ring_frame_buffer_tb;

    localparam int NUM_LEDS       = 48;
    localparam int BRIGHT_MAX     = 15;
    localparam int NO_CHANGE_CODE = 255;
    localparam int SETTLE_CYCLES  = 80;

    // kind code that the block ignores
    localparam logic [2:0] KIND_UNUSED = 3'd7;

    // one ring layout, all seven registers
    typedef struct {
        int size;
        int a_start;
        int a_offset;
        int a_rev;
        int b_start;
        int b_offset;
        int b_rev;
    } t_ring_layout;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    lrfb_pkg::t_cmd    i_cmd;
    logic              busy;
    logic              o_strobe;
    lrfb_pkg::t_result o_result;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [2:0]        i_cfg_index;
    logic [6:0]        i_cfg_data;

    // shadow of the pixel store
    logic [7:0] led_red   [NUM_LEDS];
    logic [7:0] led_green [NUM_LEDS];
    logic [7:0] led_blue  [NUM_LEDS];
    logic [7:0] led_level [NUM_LEDS];

    // shadow of the ring registers
    logic [6:0] ring_size;
    logic [5:0] ring_a_start;
    logic [5:0] ring_a_offset;
    logic       ring_a_rev;
    logic [5:0] ring_b_start;
    logic [5:0] ring_b_offset;
    logic       ring_b_rev;

    lrfb_pkg::t_result pixel_words_q[$];
    lrfb_pkg::t_result want;
    int                errors;
    bit                allow_gaps;

    led_ring_frame_buffer #(
        .NUM_LEDS       (NUM_LEDS),
        .BRIGHT_MAX     (BRIGHT_MAX),
        .NO_CHANGE_CODE (NO_CHANGE_CODE)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_cmd       (i_cmd),
        .busy        (busy),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("led_ring_frame_buffer: mismatch");
        $finish;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // color and brightness write of one store entry, dropped past the store
    function automatic void store_pixel(int idx, lrfb_pkg::t_cmd c);
        if (idx < NUM_LEDS) begin
            if (c.level != NO_CHANGE_CODE)
                led_level[idx] = c.level;
            led_red[idx]   = c.red;
            led_green[idx] = c.green;
            led_blue[idx]  = c.blue;
        end
    endfunction

    // ring position to store index, true modulo, size zero acts as one
    function automatic int ring_index(int pos, int base, int offset, bit rev);
        int n;
        int t;
        n = (ring_size == 0) ? 1 : int'(ring_size);
        t = rev ? offset - pos : offset + pos;
        t = t % n;
        if (t < 0)
            t += n;
        return base + t;
    endfunction

    // channel times brightness over the maximum, saturated
    function automatic logic [7:0] scale_channel(logic [7:0] ch, logic [7:0] lvl);
        int v;
        v = int'(ch) * int'(lvl) / BRIGHT_MAX;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    // update the shadow store for one accepted command, queue refresh words
    function automatic void apply_cmd(lrfb_pkg::t_cmd c);
        lrfb_pkg::t_result w;
        case (c.kind)
            lrfb_pkg::KIND_SET: begin
                store_pixel(c.first_index, c);
            end
            lrfb_pkg::KIND_BAR: begin
                for (int p = c.first_index; p < c.end_index; p++)
                    store_pixel(p, c);
            end
            lrfb_pkg::KIND_RING_A: begin
                for (int p = c.first_index; p < c.end_index; p++)
                    store_pixel(ring_index(p, ring_a_start, ring_a_offset, ring_a_rev), c);
            end
            lrfb_pkg::KIND_RING_B: begin
                for (int p = c.first_index; p < c.end_index; p++)
                    store_pixel(ring_index(p, ring_b_start, ring_b_offset, ring_b_rev), c);
            end
            lrfb_pkg::KIND_FILL: begin
                for (int p = 0; p < NUM_LEDS; p++)
                    store_pixel(p, c);
            end
            lrfb_pkg::KIND_BRIGHT: begin
                if (c.level != NO_CHANGE_CODE && c.level <= BRIGHT_MAX)
                    for (int p = 0; p < NUM_LEDS; p++)
                        led_level[p] = c.level;
            end
            lrfb_pkg::KIND_REFRESH: begin
                for (int i = NUM_LEDS - 1; i >= 0; i--) begin
                    w.out_green  = scale_channel(led_green[i], led_level[i]);
                    w.out_red    = scale_channel(led_red[i], led_level[i]);
                    w.out_blue   = scale_channel(led_blue[i], led_level[i]);
                    w.last_pixel = (i == 0);
                    pixel_words_q.push_back(w);
                end
            end
            default: begin
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // result checker
    // ---------------------------------------------------------------

    // compare each refresh word with the oldest expected word
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pixel_words_q.size() == 0) begin
                $error("unexpected word: green %0d red %0d blue %0d last %0d",
                       o_result.out_green, o_result.out_red, o_result.out_blue,
                       o_result.last_pixel);
                errors++;
            end else begin
                want = pixel_words_q.pop_front();
                if (o_result.out_green !== want.out_green) begin
                    $error("out_green: expected %0d actual %0d",
                           want.out_green, o_result.out_green);
                    errors++;
                end
                if (o_result.out_red !== want.out_red) begin
                    $error("out_red: expected %0d actual %0d", want.out_red, o_result.out_red);
                    errors++;
                end
                if (o_result.out_blue !== want.out_blue) begin
                    $error("out_blue: expected %0d actual %0d",
                           want.out_blue, o_result.out_blue);
                    errors++;
                end
                if (o_result.last_pixel !== want.last_pixel) begin
                    $error("last_pixel: expected %0d actual %0d",
                           want.last_pixel, o_result.last_pixel);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    // random pause after a command word, mostly short
    task automatic idle_after_cmd();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (!allow_gaps || r < 50)
            n = 0;
        else if (r < 90)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(10, 40);
        if (n > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // present one command word and hold it until taken
    task automatic send_cmd(input lrfb_pkg::t_cmd c);
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        apply_cmd(c);
        idle_after_cmd();
    endtask

    // hold commands off until every refresh word is back
    task automatic hold_until_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pixel_words_q.size() != 0) @(posedge i_clk);
    endtask

    // one register write on the config channel
    task automatic cfg_write(input logic [2:0] idx, input int data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[6:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            lrfb_pkg::CFG_RING_SIZE:      ring_size     = data[6:0];
            lrfb_pkg::CFG_RING_A_START:   ring_a_start  = data[5:0];
            lrfb_pkg::CFG_RING_A_OFFSET:  ring_a_offset = data[5:0];
            lrfb_pkg::CFG_RING_A_REVERSE: ring_a_rev    = data[0];
            lrfb_pkg::CFG_RING_B_START:   ring_b_start  = data[5:0];
            lrfb_pkg::CFG_RING_B_OFFSET:  ring_b_offset = data[5:0];
            lrfb_pkg::CFG_RING_B_REVERSE: ring_b_rev    = data[0];
            default: ;
        endcase
    endtask

    // wait for an idle block, then write all ring registers
    task automatic load_layout(input t_ring_layout s);
        hold_until_drained();
        while (busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_write(lrfb_pkg::CFG_RING_SIZE, s.size);
        cfg_write(lrfb_pkg::CFG_RING_A_START, s.a_start);
        cfg_write(lrfb_pkg::CFG_RING_A_OFFSET, s.a_offset);
        cfg_write(lrfb_pkg::CFG_RING_A_REVERSE, s.a_rev);
        cfg_write(lrfb_pkg::CFG_RING_B_START, s.b_start);
        cfg_write(lrfb_pkg::CFG_RING_B_OFFSET, s.b_offset);
        cfg_write(lrfb_pkg::CFG_RING_B_REVERSE, s.b_rev);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic t_ring_layout random_layout();
        t_ring_layout s;
        s.size     = $urandom_range(1, 64);
        s.a_start  = $urandom_range(0, 63);
        s.a_offset = $urandom_range(0, 63);
        s.a_rev    = $urandom_range(0, 1);
        s.b_start  = $urandom_range(0, 63);
        s.b_offset = $urandom_range(0, 63);
        s.b_rev    = $urandom_range(0, 1);
        return s;
    endfunction

    function automatic lrfb_pkg::t_cmd make_cmd(logic [2:0] kind, int r, int g, int b,
                                                int lvl, int first, int last);
        lrfb_pkg::t_cmd c;
        c.kind        = kind;
        c.red         = r[7:0];
        c.green       = g[7:0];
        c.blue        = b[7:0];
        c.level       = lvl[7:0];
        c.first_index = first[5:0];
        c.end_index   = last[6:0];
        return c;
    endfunction

    // random command of a given kind: mostly useful bars and levels
    function automatic lrfb_pkg::t_cmd random_cmd(logic [2:0] kind);
        lrfb_pkg::t_cmd c;
        int             r;
        int             first;
        int             last;
        r = $urandom_range(0, 99);
        first = $urandom_range(0, 63);
        if (r < 70)
            last = $urandom_range(first + 1, 64);
        else if (r < 85)
            last = $urandom_range(0, first);
        else
            last = $urandom_range(0, 64);
        c = make_cmd(kind, $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 255), first, last);
        r = $urandom_range(0, 99);
        if (r < 25)
            c.level = NO_CHANGE_CODE;
        else if (r < 55 || kind == lrfb_pkg::KIND_BRIGHT)
            c.level = $urandom_range(0, BRIGHT_MAX);
        return c;
    endfunction

    function automatic logic [2:0] random_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return lrfb_pkg::KIND_SET;
        if (r < 35) return lrfb_pkg::KIND_BAR;
        if (r < 50) return lrfb_pkg::KIND_RING_A;
        if (r < 65) return lrfb_pkg::KIND_RING_B;
        if (r < 70) return lrfb_pkg::KIND_FILL;
        if (r < 80) return lrfb_pkg::KIND_BRIGHT;
        if (r < 95) return lrfb_pkg::KIND_REFRESH;
        return KIND_UNUSED;
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // store reads back all zero after reset
    task automatic test_reset_state();
        send_cmd(make_cmd(lrfb_pkg::KIND_REFRESH, 0, 0, 0, 0, 0, 0));
    endtask

    // single pixels, store edges, fills and brightness rules
    task automatic test_pixel_writes();
        send_cmd(make_cmd(lrfb_pkg::KIND_SET, 255, 0, 1, 15, 0, 0));
        send_cmd(make_cmd(lrfb_pkg::KIND_SET, 0, 255, 128, NO_CHANGE_CODE, 47, 0));
        // past the store, dropped
        send_cmd(make_cmd(lrfb_pkg::KIND_SET, 9, 9, 9, 9, 48, 0));
        send_cmd(make_cmd(lrfb_pkg::KIND_SET, 9, 9, 9, 9, 63, 64));
        // brightness over the maximum saturates on refresh; the no-change code keeps the old level
        send_cmd(make_cmd(lrfb_pkg::KIND_SET, 255, 255, 255, 200, 5, 0));
        send_cmd(make_cmd(lrfb_pkg::KIND_SET, 170, 85, 60, 255, 6, 0));
        send_cmd(make_cmd(lrfb_pkg::KIND_REFRESH, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(lrfb_pkg::KIND_FILL, 1, 2, 3, NO_CHANGE_CODE, 0, 0));
        send_cmd(make_cmd(lrfb_pkg::KIND_REFRESH, 0, 0, 0, 0, 0, 0));
        // out of range and no-change levels leave brightness alone
        send_cmd(make_cmd(lrfb_pkg::KIND_BRIGHT, 0, 0, 0, 16, 0, 0));
        send_cmd(make_cmd(lrfb_pkg::KIND_BRIGHT, 0, 0, 0, NO_CHANGE_CODE, 0, 0));
        send_cmd(make_cmd(lrfb_pkg::KIND_REFRESH, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(lrfb_pkg::KIND_BRIGHT, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(lrfb_pkg::KIND_BRIGHT, 0, 0, 0, 15, 0, 0));
        send_cmd(make_cmd(KIND_UNUSED, 255, 255, 255, 0, 63, 64));
        send_cmd(make_cmd(lrfb_pkg::KIND_REFRESH, 0, 0, 0, 0, 0, 0));
    endtask

    // empty bars, full linear bar, ring bars past the ring at reset layout
    task automatic test_bars();
        send_cmd(make_cmd(lrfb_pkg::KIND_BAR, 200, 10, 10, 3, 10, 10));
        send_cmd(make_cmd(lrfb_pkg::KIND_BAR, 200, 10, 10, 3, 40, 30));
        send_cmd(make_cmd(lrfb_pkg::KIND_BAR, 20, 40, 60, 7, 0, 64));
        send_cmd(make_cmd(lrfb_pkg::KIND_RING_A, 90, 0, 45, 12, 0, 30));
        send_cmd(make_cmd(lrfb_pkg::KIND_RING_B, 0, 99, 255, NO_CHANGE_CODE, 20, 64));
        send_cmd(make_cmd(lrfb_pkg::KIND_REFRESH, 0, 0, 0, 0, 0, 0));
    endtask

    // ring bars under extreme and random layouts
    task automatic test_ring_layouts();
        t_ring_layout layouts[5];
        layouts[0] = '{64, 0, 63, 0, 63, 0, 1};
        layouts[1] = '{0, 47, 5, 1, 10, 63, 0};
        layouts[2] = '{1, 20, 0, 0, 40, 1, 1};
        layouts[3] = '{13, 30, 17, 1, 2, 40, 0};
        layouts[4] = random_layout();
        foreach (layouts[i]) begin
            load_layout(layouts[i]);
            repeat (2) begin
                send_cmd(random_cmd(lrfb_pkg::KIND_RING_A));
                send_cmd(random_cmd(lrfb_pkg::KIND_RING_B));
            end
            send_cmd(random_cmd(lrfb_pkg::KIND_REFRESH));
        end
    endtask

    // mixed random traffic in phases, one phase with no gaps
    task automatic test_random_traffic();
        for (int ph = 0; ph < 4; ph++) begin
            if (ph == 1)
                hold_until_drained();
            else
                load_layout(random_layout());
            allow_gaps = (ph != 2);
            repeat (22) send_cmd(random_cmd(random_kind()));
            send_cmd(random_cmd(lrfb_pkg::KIND_REFRESH));
        end
        allow_gaps = 1'b1;
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial begin
        errors      = 0;
        allow_gaps  = 1'b1;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = lrfb_pkg::CFG_RING_SIZE;
        i_cfg_data  = '0;
        for (int i = 0; i < NUM_LEDS; i++) begin
            led_red[i]   = '0;
            led_green[i] = '0;
            led_blue[i]  = '0;
            led_level[i] = '0;
        end
        ring_size     = lrfb_pkg::RING_SIZE_RST;
        ring_a_start  = lrfb_pkg::RING_A_START_RST;
        ring_a_offset = lrfb_pkg::RING_A_OFFSET_RST;
        ring_a_rev    = lrfb_pkg::RING_A_REVERSE_RST;
        ring_b_start  = lrfb_pkg::RING_B_START_RST;
        ring_b_offset = lrfb_pkg::RING_B_OFFSET_RST;
        ring_b_rev    = lrfb_pkg::RING_B_REVERSE_RST;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_pixel_writes();
        test_bars();
        test_ring_layouts();
        test_random_traffic();

        // drain with a limit, then let the pipeline settle
        @(negedge i_clk);
        start <= 1'b0;
        for (int n = 0; n < 5000 && pixel_words_q.size() != 0; n++)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pixel_words_q.size() != 0) begin
            $error("%0d expected words never arrived", pixel_words_q.size());
            errors++;
        end

        if (errors == 0) begin
            $display("led_ring_frame_buffer: match");
        end else begin
            $display("led_ring_frame_buffer: mismatch");
        end
        $finish;
    end

endmodule
